[hw/rtl/mppt_po_pkg.sv]
// ----------------------------------------------------------------------------
// MPPT perturb-and-observe package
// Shared field widths, register indexes, result codes and bus structs.
// ----------------------------------------------------------------------------
package mppt_po_pkg;

    localparam int POWER_W       = 16;
    localparam int CURRENT_W     = 16;
    localparam int CHARGE_W      = 15;
    localparam int DUTY_W        = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int POWER_BITS_DEF = 16;

    // Stream widths; tdata widths rounded up to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDBY_POWER  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDBY_CHARGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_POWER   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_START     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_MAX       = 3'd4;

    // Register reset values
    localparam logic [POWER_W-1:0]  RST_STANDBY_POWER  = 16'd100;
    localparam logic [CHARGE_W-1:0] RST_STANDBY_CHARGE = 15'd100;
    localparam logic [POWER_W-1:0]  RST_ENABLE_POWER   = 16'd500;
    localparam logic [DUTY_W-1:0]   RST_DUTY_START     = 8'd159;
    localparam logic [DUTY_W-1:0]   RST_DUTY_MAX       = 8'd160;

    typedef enum logic [1:0] {
        STEP_NONE  = 2'd0,
        STEP_LIMIT = 2'd1,
        STEP_PO    = 2'd2
    } t_step_kind;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_ENABLE  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [POWER_W-1:0]  standby_power_limit;
        logic [CHARGE_W-1:0] standby_charge_limit;
        logic [POWER_W-1:0]  enable_power_limit;
        logic [DUTY_W-1:0]   duty_start;
        logic [DUTY_W-1:0]   duty_max;
    } t_cfg;

    typedef struct packed {
        logic [CHARGE_W-1:0]         max_charge;
        logic signed [CURRENT_W-1:0] battery_current;
        logic [POWER_W-1:0]          solar_power;
    } t_sample;

    typedef struct packed {
        logic               enabled;
        logic [DUTY_W-1:0]  high_compare;
        logic [DUTY_W:0]    low_compare;
        logic               moved_up;
        t_step_kind         step_kind;
        t_mode              mode_change;
    } t_result;

endpackage

[hw/rtl/mppt_po_cfg.sv]
// ----------------------------------------------------------------------------
// MPPT configuration registers
// Write-only register bank for thresholds and duty limits.
// ----------------------------------------------------------------------------
module mppt_po_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mppt_po_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mppt_po_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output mppt_po_pkg::t_cfg                   o_cfg
);
    import mppt_po_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STANDBY_POWER:  n_cfg.standby_power_limit  = i_cfg_wdata[POWER_W-1:0];
                CFG_STANDBY_CHARGE: n_cfg.standby_charge_limit = i_cfg_wdata[CHARGE_W-1:0];
                CFG_ENABLE_POWER:   n_cfg.enable_power_limit   = i_cfg_wdata[POWER_W-1:0];
                CFG_DUTY_START:     n_cfg.duty_start           = i_cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:       n_cfg.duty_max             = i_cfg_wdata[DUTY_W-1:0];
                default:            n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.standby_power_limit  <= RST_STANDBY_POWER;
            r_cfg.standby_charge_limit <= RST_STANDBY_CHARGE;
            r_cfg.enable_power_limit   <= RST_ENABLE_POWER;
            r_cfg.duty_start           <= RST_DUTY_START;
            r_cfg.duty_max             <= RST_DUTY_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/mppt_po_step.sv]
// ----------------------------------------------------------------------------
// MPPT tracker step
// Tracker state and the combinational mode/duty update for one sample.
// ----------------------------------------------------------------------------
module mppt_po_step #(
    parameter int POWER_BITS = mppt_po_pkg::POWER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,   // sample consumed this cycle
    input  mppt_po_pkg::t_cfg    i_cfg,
    input  mppt_po_pkg::t_sample i_sample,
    output mppt_po_pkg::t_result o_result
);
    import mppt_po_pkg::*;

    // Power compares use the low bits only; the sample field is 16 bits wide
    localparam int PW = (POWER_BITS < POWER_W) ? POWER_BITS : POWER_W;

    logic [DUTY_W-1:0] r_duty;
    logic              r_running;
    logic              r_last_up;
    logic [PW-1:0]     r_prev_power;

    logic [DUTY_W-1:0] n_duty;
    logic              n_running;
    logic              n_last_up;
    logic [PW-1:0]     n_prev_power;

    logic [PW-1:0]     power;
    logic              go_standby;
    logic              go_enable;
    logic              do_step;
    logic              cur_limit;
    logic              rose;
    logic              step_up;
    logic [DUTY_W-1:0] duty_base;
    logic [DUTY_W:0]   duty_inc;
    logic [DUTY_W-1:0] duty_up;
    logic [DUTY_W-1:0] duty_down;

    always_comb begin
        power      = i_sample.solar_power[PW-1:0];
        go_standby = r_running && (power < i_cfg.standby_power_limit[PW-1:0])
                     && (i_sample.max_charge > i_cfg.standby_charge_limit);
        go_enable  = !r_running && (power > i_cfg.enable_power_limit[PW-1:0]);
        do_step    = r_running || go_enable;

        // signed current against an unsigned limit: widen both to 17 bits
        cur_limit  = $signed({i_sample.battery_current[CURRENT_W-1],
                              i_sample.battery_current})
                     >= $signed({2'b00, i_sample.max_charge});
        rose       = power > r_prev_power;
        step_up    = !cur_limit && (rose ~^ r_last_up);

        duty_base  = go_enable ? i_cfg.duty_start : r_duty;
        duty_inc   = {1'b0, duty_base} + {{DUTY_W{1'b0}}, 1'b1};
        duty_up    = (duty_inc > {1'b0, i_cfg.duty_max}) ? i_cfg.duty_max
                                                         : duty_inc[DUTY_W-1:0];
        duty_down  = (duty_base == '0) ? '0 : duty_base - {{(DUTY_W-1){1'b0}}, 1'b1};

        n_running    = go_standby ? 1'b0 : (go_enable ? 1'b1 : r_running);
        n_duty       = do_step ? (step_up ? duty_up : duty_down) : r_duty;
        n_last_up    = do_step ? step_up : r_last_up;
        n_prev_power = do_step ? power : r_prev_power;
    end

    always_comb begin
        o_result.enabled      = n_running;
        o_result.high_compare = n_duty;
        o_result.low_compare  = {1'b0, n_duty} + {{DUTY_W{1'b0}}, 1'b1};
        o_result.moved_up     = n_last_up;
        if (!do_step) begin
            o_result.step_kind = STEP_NONE;
        end else if (cur_limit) begin
            o_result.step_kind = STEP_LIMIT;
        end else begin
            o_result.step_kind = STEP_PO;
        end
        if (go_standby) begin
            o_result.mode_change = MODE_STANDBY;
        end else if (go_enable) begin
            o_result.mode_change = MODE_ENABLE;
        end else begin
            o_result.mode_change = MODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= '0;
            r_running    <= 1'b0;
            r_last_up    <= 1'b0;
            r_prev_power <= '0;
        end else if (i_advance) begin
            r_duty       <= n_duty;
            r_running    <= n_running;
            r_last_up    <= n_last_up;
            r_prev_power <= n_prev_power;
        end
    end

    a_limit_goes_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.step_kind == STEP_LIMIT) |-> !o_result.moved_up)
        else $error("current-limit step did not go down");

    a_state_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |=> (r_running == $past(o_result.enabled))
                      && (r_duty == $past(o_result.high_compare)))
        else $error("tracker state does not match delivered result");

    a_up_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.step_kind == STEP_PO && o_result.moved_up)
        |-> (o_result.high_compare <= i_cfg.duty_max))
        else $error("up step exceeded duty maximum");

    a_enable_from_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.mode_change == MODE_ENABLE)
        |-> (!r_running && o_result.enabled && o_result.step_kind != STEP_NONE))
        else $error("enable transaction from a running tracker");

    a_idle_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.step_kind == STEP_NONE) |=> $stable(r_prev_power))
        else $error("power memory changed without a step");

endmodule

[hw/rtl/mppt_perturb_observe_pwm.sv]
// ----------------------------------------------------------------------------
// MPPT perturb-and-observe PWM controller
// Stream wrapper: input register, tracker step, registered result.
// ----------------------------------------------------------------------------
// One sample transaction can be accepted every clock cycle while the output
// is not stalled; its result appears on the master side after passing the
// input register and then the result register. The rate is set by the
// tracker state loop, which closes combinationally through a few compares
// and one saturating duty increment. Output back-pressure stalls the input
// register; while a finished result waits, the input side accepts only
// into an empty input register. Configuration writes take effect on the
// next cycle and should be made only while no sample is in flight.
module mppt_perturb_observe_pwm #(
    parameter int POWER_BITS = mppt_po_pkg::POWER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [mppt_po_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mppt_po_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] solar_power, [31:16] battery_current, [46:32] max_charge, [47] zero
    input  logic [mppt_po_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] enabled, [8:1] high_compare, [17:9] low_compare, [18] moved_up,
    // [23:19] zero
    output logic [mppt_po_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] step_kind, [3:2] mode_change
    output logic [mppt_po_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import mppt_po_pkg::*;

    t_cfg    cfg;
    t_result step_result;
    logic    s_accept;
    logic    advance;

    logic    r_in_valid;
    logic    n_in_valid;
    t_sample r_sample;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;

    mppt_po_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mppt_po_step #(
        .POWER_BITS (POWER_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (cfg),
        .i_sample  (r_sample),
        .o_result  (step_result)
    );

    always_comb begin
        advance       = r_in_valid && (!r_out_valid || m_axis_tready);
        s_axis_tready = !r_in_valid || advance;
        s_accept      = s_axis_tvalid && s_axis_tready;
        n_in_valid    = s_accept || (r_in_valid && !advance);
        n_out_valid   = advance || (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sample <= s_axis_tdata[POWER_W+CURRENT_W+CHARGE_W-1:0];
        end
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_result.moved_up, r_result.low_compare,
                            r_result.high_compare, r_result.enabled};
    assign m_axis_tuser  = {r_result.mode_change, r_result.step_kind};

endmodule

[bench/tb_mppt_perturb_observe_pwm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPPT perturb-and-observe PWM controller testbench
// Drives power/current sample transactions through the stream slave port.
// Register settings change between phases while the block is idle.
// A scoreboard tracks duty, run state and step direction per accepted sample.
// Each result transaction is checked field by field against the scoreboard.
// ----------------------------------------------------------------------------
module tb_mppt_perturb_observe_pwm;
    import mppt_po_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class tracker_scoreboard;
        t_cfg             cfg;
        logic [DUTY_W-1:0]  duty;
        bit               running;
        bit               last_up;
        logic [POWER_W-1:0] prev_power;
        t_result          expected_ticks[$];
        int               errors;

        function new();
            cfg.standby_power_limit  = RST_STANDBY_POWER;
            cfg.standby_charge_limit = RST_STANDBY_CHARGE;
            cfg.enable_power_limit   = RST_ENABLE_POWER;
            cfg.duty_start           = RST_DUTY_START;
            cfg.duty_max             = RST_DUTY_MAX;
            duty       = '0;
            running    = 1'b0;
            last_up    = 1'b0;
            prev_power = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_STANDBY_POWER:  cfg.standby_power_limit  = val;
                CFG_STANDBY_CHARGE: cfg.standby_charge_limit = val[CHARGE_W-1:0];
                CFG_ENABLE_POWER:   cfg.enable_power_limit   = val;
                CFG_DUTY_START:     cfg.duty_start           = val[DUTY_W-1:0];
                CFG_DUTY_MAX:       cfg.duty_max             = val[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // One control tick: optional mode change, then at most one duty step
        function void note_sample(t_sample s);
            t_result      r;
            int           cur_i;
            int           lim_i;
            bit           take_step;
            bit           go_up;
            logic [DUTY_W:0] next_duty;
            t_step_kind   kind;
            t_mode        mode;
            cur_i     = $signed(s.battery_current);
            lim_i     = s.max_charge;
            kind      = STEP_NONE;
            mode      = MODE_NONE;
            take_step = 1'b0;
            go_up     = 1'b0;
            if (running && s.solar_power < cfg.standby_power_limit &&
                s.max_charge > cfg.standby_charge_limit) begin
                running   = 1'b0;
                mode      = MODE_STANDBY;
                take_step = 1'b1;
            end else if (!running && s.solar_power > cfg.enable_power_limit) begin
                duty      = cfg.duty_start;
                running   = 1'b1;
                mode      = MODE_ENABLE;
                take_step = 1'b1;
            end else begin
                take_step = running;
            end
            if (take_step) begin
                if (cur_i >= lim_i) begin
                    kind = STEP_LIMIT;
                end else begin
                    go_up = (s.solar_power > prev_power) ? last_up : !last_up;
                    kind  = STEP_PO;
                end
                // up step clamps to duty_max, even from above it
                if (go_up) begin
                    next_duty = duty + 9'd1;
                    if (next_duty > cfg.duty_max)
                        next_duty = cfg.duty_max;
                    duty = next_duty[DUTY_W-1:0];
                end else if (duty != 0) begin
                    duty = duty - 1'b1;
                end
                last_up    = go_up;
                prev_power = s.solar_power;
            end
            r.enabled      = running;
            r.high_compare = duty;
            r.low_compare  = {1'b0, duty} + 9'd1;
            r.moved_up     = last_up;
            r.step_kind    = kind;
            r.mode_change  = mode;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_tick(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            t_result e;
            if (expected_ticks.size() == 0) begin
                $error("result transaction with nothing pending: tdata=%h tuser=%h",
                       data, user);
                errors++;
            end else begin
                e = expected_ticks.pop_front();
                compare_field("enabled",      e.enabled,      data[0]);
                compare_field("high_compare", e.high_compare, data[8:1]);
                compare_field("low_compare",  e.low_compare,  data[17:9]);
                compare_field("moved_up",     e.moved_up,     data[18]);
                compare_field("step_kind",    e.step_kind,    user[1:0]);
                compare_field("mode_change",  e.mode_change,  user[3:2]);
            end
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [15:0] solar_power, [31:16] battery_current, [46:32] max_charge, [47] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] enabled, [8:1] high_compare, [17:9] low_compare, [18] moved_up
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [1:0] step_kind, [3:2] mode_change
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    tracker_scoreboard sb = new();

    bit                  no_idle = 1'b0;
    int                  gap_pct = 30;
    int                  cycle_count = 0;
    logic [POWER_W-1:0]  walk_power = 16'd500;
    logic [CHARGE_W-1:0] hold_charge = 15'd1000;
    logic [POWER_W-1:0]  cur_sp = RST_STANDBY_POWER;
    logic [CHARGE_W-1:0] cur_sc = RST_STANDBY_CHARGE;
    logic [POWER_W-1:0]  cur_ep = RST_ENABLE_POWER;

    mppt_perturb_observe_pwm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure
    initial begin
        forever begin
            if (no_idle) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 30))
                    @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_tick(m_axis_tdata, m_axis_tuser);
    end

    task automatic drive_sample(t_sample s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, s};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_sample(s);
        if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send(int pwr, int cur, int chg);
        t_sample s;
        s.solar_power     = pwr[POWER_W-1:0];
        s.battery_current = cur[CURRENT_W-1:0];
        s.max_charge      = chg[CHARGE_W-1:0];
        drive_sample(s);
    endtask

    // Drain everything in flight, plus margin for the two-stage pipe
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [15:0] sp, logic [15:0] sc, logic [15:0] ep,
                                 logic [15:0] ds, logic [15:0] dm);
        logic [CFG_INDEX_W-1:0] idx[5];
        logic [CFG_DATA_W-1:0]  vals[5];
        idx  = '{CFG_STANDBY_POWER, CFG_STANDBY_CHARGE, CFG_ENABLE_POWER,
                 CFG_DUTY_START, CFG_DUTY_MAX};
        vals = '{sp, sc, ep, ds, dm};
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx[i], vals[i]);
        end
        // unmapped index must be ignored
        i_cfg_index <= CFG_DUTY_MAX + CFG_INDEX_W'($urandom_range(1, 3));
        i_cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_sp = sp;
        cur_sc = sc[CHARGE_W-1:0];
        cur_ep = ep;
    endtask

    function automatic int pick_limit(int max_val);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return max_val;
            2:       return $urandom_range(0, (max_val < 3000) ? max_val : 3000);
            default: return $urandom_range(0, max_val);
        endcase
    endfunction

    // Power follows a random walk, with jumps and hits near both thresholds
    function automatic t_sample random_sample();
        t_sample s;
        int      pwr;
        int      cur;
        int      chg;
        case ($urandom_range(0, 9))
            0:       pwr = $urandom_range(0, 65535);
            1:       pwr = int'(cur_sp) + int'($urandom_range(0, 4)) - 2;
            2:       pwr = int'(cur_ep) + int'($urandom_range(0, 4)) - 2;
            default: pwr = int'(walk_power) + int'($urandom_range(0, 400)) - 200;
        endcase
        if (pwr < 0) pwr = 0;
        else if (pwr > 65535) pwr = 65535;
        walk_power = pwr[POWER_W-1:0];
        chg = hold_charge;
        case ($urandom_range(0, 15))
            0: chg = $urandom_range(0, 32767);
            1: chg = int'(cur_sc) + int'($urandom_range(0, 2)) - 1;
            default: ;
        endcase
        if (chg < 0) chg = 0;
        else if (chg > 32767) chg = 32767;
        hold_charge = chg[CHARGE_W-1:0];
        case ($urandom_range(0, 7))
            0:       cur = int'($urandom_range(0, 65535)) - 32768;
            1:       cur = chg;
            default: cur = chg + int'($urandom_range(0, 260)) - 250;
        endcase
        if (cur > 32767) cur = 32767;
        s.solar_power     = pwr[POWER_W-1:0];
        s.battery_current = cur[CURRENT_W-1:0];
        s.max_charge      = hold_charge;
        return s;
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_STANDBY_POWER;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: idle tick, enable threshold edge, saturation at max,
        // current limit incl. equality, standby thresholds
        send(0, 0, 0);
        send(500, 0, 1000);
        send(501, 0, 1000);
        send(600, 0, 1000);
        send(600, 0, 1000);
        send(700, 0, 1000);
        send(800, 0, 1000);
        send(900, 0, 1000);
        send(65535, -32768, 32767);
        send(65535, 32767, 32767);
        send(65535, 32767, 0);
        send(100, 0, 101);
        send(99, 0, 100);
        send(99, 0, 101);
        send(99, 0, 101);

        wait_idle();
        apply_setting(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send(1, 0, 1);
        send(2, 0, 1);
        send(0, 0, 1);

        // duty pinned at zero: down steps floor at zero
        wait_idle();
        apply_setting(16'h0000, 16'hFFFF, 16'h0000, 16'hFF00, 16'h0000);
        send(10, 5, 3);
        send(20, 0, 3);
        send(30, 0, 3);

        // start above the saturation bound
        wait_idle();
        apply_setting(16'hFFFF, 16'h0000, 16'h0000, 16'd200, 16'd100);
        send(0, 0, 1);
        send(5, 0, 1);
        send(6, 0, 1);
        send(4, 0, 1);

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            if (ph == 0)
                apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else if (ph == 1)
                apply_setting(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h00FF, 16'h00FF);
            else
                apply_setting(16'(pick_limit(65535)),
                              16'(pick_limit(32767) | ($urandom_range(0, 1) << 15)),
                              16'(pick_limit(65535)),
                              16'(pick_limit(255) | ($urandom_range(0, 255) << 8)),
                              16'(pick_limit(255) | ($urandom_range(0, 255) << 8)));
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 25;
                default: gap_pct = 50;
            endcase
            no_idle     = (ph == 9);
            walk_power  = cur_ep;
            hold_charge = 15'($urandom_range(0, 32767));
            for (int n = 0; n < 85; n++)
                drive_sample(random_sample());
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
